// ===== rtl/bdt_pkg.sv =====
// ----------------------------------------------------------------------------
// Button debounce and timebase package
// Item types, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package bdt_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_BACKLIGHT_RELOAD = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLEEP_RELOAD     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TICKS_PER_SECOND = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TICKS_PER_ADC    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SECONDS_PER_LOG  = 3'd4;

    localparam logic [15:0] BACKLIGHT_RELOAD_RST = 16'd60;
    localparam logic [15:0] SLEEP_RELOAD_RST     = 16'd300;
    localparam logic [9:0]  TICKS_PER_SECOND_RST = 10'd992;
    localparam logic [7:0]  TICKS_PER_ADC_RST    = 8'd125;
    localparam logic [7:0]  SECONDS_PER_LOG_RST  = 8'd59;

    typedef struct packed {
        logic up_pin;
        logic select_pin;
        logic down_pin;
    } t_in_item;

    typedef struct packed {
        logic       up_event;
        logic       select_event;
        logic       down_event;
        logic       redraw_due;
        logic       adc_due;
        logic       second_pulse;
        logic       log_due;
        logic [7:0] seconds_now;
        logic       backlight_level;
        logic       sleep_ok;
    } t_out_item;

endpackage

// ===== rtl/button_debounce_timebase.sv =====
// ----------------------------------------------------------------------------
// Button debounce and timebase
// Debounces three button pins and derives the ADC, second and log pulses and
// the backlight and sleep countdowns from a stream of millisecond ticks.
// ----------------------------------------------------------------------------
// An accepted item's result is registered in the output register in the cycle after it is accepted.
// Throughput is one item per cycle while the held result is not stalled, set by the single output register.
// Input is stalled only while a held result is itself stalled.
// Reset clears all histories, counters and flags and loads the register defaults.
// Configuration writes are always ready and take effect on the next item.
module button_debounce_timebase #(
    parameter int STABLE_TICKS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  bdt_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output bdt_pkg::t_out_item            o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bdt_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [bdt_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import bdt_pkg::*;

    localparam int HIST_W = STABLE_TICKS + 1;
    localparam logic [HIST_W-1:0] HIST_FIRE = {1'b1, {STABLE_TICKS{1'b0}}};

    logic [15:0]       r_backlight_reload;
    logic [15:0]       r_sleep_reload;
    logic [9:0]        r_ticks_per_second;
    logic [7:0]        r_ticks_per_adc;
    logic [7:0]        r_seconds_per_log;

    logic [HIST_W-1:0] r_up_hist, n_up_hist;
    logic [HIST_W-1:0] r_sel_hist, n_sel_hist;
    logic [HIST_W-1:0] r_dn_hist, n_dn_hist;
    logic [7:0]        r_adc_count, n_adc_count;
    logic [9:0]        r_tick_count, n_tick_count;
    logic [7:0]        r_second_count, n_second_count;
    logic [15:0]       r_backlight_count, n_backlight_count;
    logic [15:0]       r_sleep_count, n_sleep_count;
    logic              r_backlight_pin, n_backlight_pin;
    logic              r_sleep_flag, n_sleep_flag;
    logic              r_out_valid;
    t_out_item         r_out_data, n_out_data;

    logic              in_accept;
    logic              up_ev, sel_ev, dn_ev, any_ev;
    logic              adc_hit, sec_hit, log_hit;
    logic [7:0]        adc_inc, sec_inc;
    logic [9:0]        tick_inc;
    logic [15:0]       bl_loaded, sl_loaded;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_up_hist  = {r_up_hist[HIST_W-2:0], ~i_in_data.up_pin};
        n_sel_hist = {r_sel_hist[HIST_W-2:0], ~i_in_data.select_pin};
        n_dn_hist  = {r_dn_hist[HIST_W-2:0], ~i_in_data.down_pin};
        up_ev      = (n_up_hist == HIST_FIRE);
        sel_ev     = (n_sel_hist == HIST_FIRE);
        dn_ev      = (n_dn_hist == HIST_FIRE);
        any_ev     = up_ev || sel_ev || dn_ev;

        bl_loaded = any_ev ? r_backlight_reload : r_backlight_count;
        sl_loaded = any_ev ? r_sleep_reload : r_sleep_count;

        adc_inc     = r_adc_count + 8'd1;
        adc_hit     = (adc_inc == r_ticks_per_adc);
        n_adc_count = adc_hit ? 8'd0 : adc_inc;

        tick_inc     = r_tick_count + 10'd1;
        sec_hit      = (tick_inc == r_ticks_per_second);
        n_tick_count = sec_hit ? 10'd0 : tick_inc;

        sec_inc           = r_second_count + 8'd1;
        log_hit           = sec_hit && (sec_inc == r_seconds_per_log);
        n_second_count    = r_second_count;
        n_backlight_count = bl_loaded;
        n_sleep_count     = sl_loaded;
        n_backlight_pin   = r_backlight_pin;
        n_sleep_flag      = r_sleep_flag;
        if (sec_hit) begin
            n_second_count  = log_hit ? 8'd0 : sec_inc;
            n_backlight_pin = (bl_loaded == 16'd0);
            n_sleep_flag    = (sl_loaded == 16'd0);
            if (bl_loaded != 16'd0) begin
                n_backlight_count = bl_loaded - 16'd1;
            end
            if (sl_loaded != 16'd0) begin
                n_sleep_count = sl_loaded - 16'd1;
            end
        end

        n_out_data.up_event        = up_ev;
        n_out_data.select_event    = sel_ev;
        n_out_data.down_event      = dn_ev;
        n_out_data.redraw_due      = any_ev || sec_hit;
        n_out_data.adc_due         = adc_hit;
        n_out_data.second_pulse    = sec_hit;
        n_out_data.log_due         = log_hit;
        n_out_data.seconds_now     = n_second_count;
        n_out_data.backlight_level = n_backlight_pin;
        n_out_data.sleep_ok        = n_sleep_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_backlight_reload <= BACKLIGHT_RELOAD_RST;
            r_sleep_reload     <= SLEEP_RELOAD_RST;
            r_ticks_per_second <= TICKS_PER_SECOND_RST;
            r_ticks_per_adc    <= TICKS_PER_ADC_RST;
            r_seconds_per_log  <= SECONDS_PER_LOG_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_BACKLIGHT_RELOAD: r_backlight_reload <= i_cfg_data;
                CFG_SLEEP_RELOAD:     r_sleep_reload     <= i_cfg_data;
                CFG_TICKS_PER_SECOND: r_ticks_per_second <= i_cfg_data[9:0];
                CFG_TICKS_PER_ADC:    r_ticks_per_adc    <= i_cfg_data[7:0];
                CFG_SECONDS_PER_LOG:  r_seconds_per_log  <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_hist         <= '0;
            r_sel_hist        <= '0;
            r_dn_hist         <= '0;
            r_adc_count       <= '0;
            r_tick_count      <= '0;
            r_second_count    <= '0;
            r_backlight_count <= '0;
            r_sleep_count     <= '0;
            r_backlight_pin   <= 1'b0;
            r_sleep_flag      <= 1'b0;
            r_out_valid       <= 1'b0;
        end else begin
            if (in_accept) begin
                r_up_hist         <= n_up_hist;
                r_sel_hist        <= n_sel_hist;
                r_dn_hist         <= n_dn_hist;
                r_adc_count       <= n_adc_count;
                r_tick_count      <= n_tick_count;
                r_second_count    <= n_second_count;
                r_backlight_count <= n_backlight_count;
                r_sleep_count     <= n_sleep_count;
                r_backlight_pin   <= n_backlight_pin;
                r_sleep_flag      <= n_sleep_flag;
                r_out_valid       <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

// ===== sim/button_debounce_timebase_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Button debounce and timebase testbench
// Sends millisecond ticks with pin levels that mimic real presses, bounces and
// noise. Register settings cover the defaults, the extremes, zero periods and
// periods lowered below a running count. Each result is checked field by field
// against an in-bench timebase model. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module button_debounce_timebase_tb;
    import bdt_pkg::*;

    localparam int STABLE_TICKS = 12;
    localparam int HIST_W = STABLE_TICKS + 1;
    localparam logic [HIST_W-1:0] PRESS_PATTERN = {1'b1, {STABLE_TICKS{1'b0}}};
    localparam int LONG_HOLD = 150;
    localparam int DRAIN_LIMIT = 2000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    t_in_item               i_in_data = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    t_out_item              o_out_data;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    // Register copies.
    logic [15:0] backlight_reload = BACKLIGHT_RELOAD_RST;
    logic [15:0] sleep_reload = SLEEP_RELOAD_RST;
    logic [9:0]  ticks_per_second = TICKS_PER_SECOND_RST;
    logic [7:0]  ticks_per_adc = TICKS_PER_ADC_RST;
    logic [7:0]  seconds_per_log = SECONDS_PER_LOG_RST;

    // Timebase state; button order is up, select, down.
    logic [HIST_W-1:0] pin_history [3] = '{default: '0};
    logic [7:0]  adc_count = '0;
    logic [9:0]  tick_count = '0;
    logic [7:0]  second_count = '0;
    logic [15:0] backlight_count = '0;
    logic [15:0] sleep_count = '0;
    logic        backlight_off = 1'b0;
    logic        sleep_flag = 1'b0;

    t_out_item tick_results_due [$];
    int failures = 0;

    bit tx_idle = 1'b0;
    bit rx_idle = 1'b0;
    bit long_hold = 1'b0;

    // Press generator state per button.
    bit btn_low [3] = '{default: 1'b0};
    int btn_left [3] = '{default: 0};

    button_debounce_timebase DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic advance_timebase(input t_in_item pins);
        t_out_item  r;
        logic [2:0] level;
        logic [2:0] press;
        level = {pins.up_pin, pins.select_pin, pins.down_pin};
        r = '0;
        for (int b = 0; b < 3; b++) begin
            pin_history[b] = {pin_history[b][HIST_W-2:0], ~level[2-b]};
            press[b] = (pin_history[b] == PRESS_PATTERN);
        end
        if (|press) begin
            backlight_count = backlight_reload;
            sleep_count = sleep_reload;
        end
        adc_count = adc_count + 8'd1;
        if (adc_count == ticks_per_adc) begin
            adc_count = '0;
            r.adc_due = 1'b1;
        end
        tick_count = tick_count + 10'd1;
        if (tick_count == ticks_per_second) begin
            tick_count = '0;
            r.second_pulse = 1'b1;
            second_count = second_count + 8'd1;
            if (second_count == seconds_per_log) begin
                second_count = '0;
                r.log_due = 1'b1;
            end
            if (backlight_count == '0) begin
                backlight_off = 1'b1;
            end else begin
                backlight_off = 1'b0;
                backlight_count = backlight_count - 16'd1;
            end
            if (sleep_count == '0) begin
                sleep_flag = 1'b1;
            end else begin
                sleep_flag = 1'b0;
                sleep_count = sleep_count - 16'd1;
            end
        end
        r.up_event = press[0];
        r.select_event = press[1];
        r.down_event = press[2];
        r.redraw_due = (|press) | r.second_pulse;
        r.seconds_now = second_count;
        r.backlight_level = backlight_off;
        r.sleep_ok = sleep_flag;
        tick_results_due.push_back(r);
    endtask

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Mostly clean presses: a short low run, then a high run that is usually
    // long enough to register, sometimes a bounce, plus some random noise.
    function automatic t_in_item next_pins();
        t_in_item   it;
        logic [2:0] level;
        int         r;
        for (int b = 0; b < 3; b++) begin
            if (btn_left[b] == 0) begin
                btn_low[b] = !btn_low[b];
                r = $urandom_range(0, 19);
                if (btn_low[b]) begin
                    btn_left[b] = (r < 14) ? 1 : $urandom_range(2, 3);
                end else if (r < 14) begin
                    btn_left[b] = $urandom_range(12, 24);
                end else if (r < 17) begin
                    btn_left[b] = $urandom_range(1, 11);
                end else begin
                    btn_left[b] = $urandom_range(30, 90);
                end
            end
            btn_left[b]--;
            level[b] = !btn_low[b];
        end
        if ($urandom_range(0, 9) == 0) level = 3'($urandom);
        it.up_pin = level[0];
        it.select_pin = level[1];
        it.down_pin = level[2];
        return it;
    endfunction

    task automatic send_tick(input t_in_item pins);
        int gap;
        i_in_valid <= 1'b1;
        i_in_data <= pins;
        do @(posedge i_clk); while (o_in_stall);
        advance_timebase(pins);
        gap = 0;
        if (tx_idle && $urandom_range(0, 2) == 0) gap = idle_length();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic run_ticks(input int count);
        repeat (count) send_tick(next_pins());
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (tick_results_due.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_BACKLIGHT_RELOAD: backlight_reload = value;
            CFG_SLEEP_RELOAD:     sleep_reload = value;
            CFG_TICKS_PER_SECOND: ticks_per_second = value[9:0];
            CFG_TICKS_PER_ADC:    ticks_per_adc = value[7:0];
            CFG_SECONDS_PER_LOG:  seconds_per_log = value[7:0];
            default: ;
        endcase
    endtask

    // Writes every register, then the unused indexes, which must change nothing.
    task automatic configure(input logic [15:0] backlight_secs, sleep_secs,
                             input logic [15:0] second_ticks, adc_ticks, log_secs);
        wait_drained();
        write_register(CFG_BACKLIGHT_RELOAD, backlight_secs);
        write_register(CFG_SLEEP_RELOAD, sleep_secs);
        write_register(CFG_TICKS_PER_SECOND, second_ticks);
        write_register(CFG_TICKS_PER_ADC, adc_ticks);
        write_register(CFG_SECONDS_PER_LOG, log_secs);
        for (int k = CFG_SECONDS_PER_LOG + 1; k < 2 ** CFG_INDEX_W; k++) begin
            write_register(CFG_INDEX_W'(k), CFG_DATA_W'($urandom));
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_directed_presses();
        t_in_item all_high;
        all_high = '1;
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        send_tick('0);
        send_tick(t_in_item'{up_pin: 1'b0, select_pin: 1'b1, down_pin: 1'b1});
        send_tick(t_in_item'{up_pin: 1'b1, select_pin: 1'b0, down_pin: 1'b1});
        send_tick(t_in_item'{up_pin: 1'b1, select_pin: 1'b1, down_pin: 1'b0});
        repeat (14) send_tick(all_high);
    endtask

    task automatic test_reset_defaults();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        run_ticks(110);
    endtask

    task automatic test_register_extremes();
        configure(16'h0000, 16'hFFFF, 16'hFC01, 16'hFF01, 16'hFF01);
        run_ticks(80);
        configure(16'hFFFF, 16'h0000, 16'h0002, 16'h00FF, 16'h00FF);
        run_ticks(80);
    endtask

    task automatic test_zero_periods();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        configure(16'd3, 16'd7, 16'd1, 16'd0, 16'd0);
        run_ticks(280);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    task automatic test_lowered_periods();
        configure(16'd2, 16'd5, 16'd1, 16'd200, 16'd200);
        run_ticks(50);
        configure(16'd2, 16'd5, 16'd1, 16'd5, 16'd3);
        run_ticks(220);
    endtask

    task automatic test_long_second();
        configure(16'd1, 16'd2, 16'd1023, 16'd7, 16'd2);
        run_ticks(30);
        configure(16'd1, 16'd2, 16'd0, 16'd7, 16'd2);
        run_ticks(1000);
    endtask

    task automatic test_backpressure();
        configure(16'd2, 16'd4, 16'd3, 16'd4, 16'd3);
        long_hold = 1'b1;
        tx_idle = 1'b0;
        run_ticks(40);
        tx_idle = 1'b1;
        run_ticks(20);
        wait_drained();
        run_ticks(20);
    endtask

    task automatic test_random_settings();
        logic [15:0] backlight_secs;
        logic [15:0] sleep_secs;
        repeat (3) begin
            backlight_secs = 16'($urandom_range(0, 6));
            sleep_secs = 16'($urandom_range(0, 10));
            configure(backlight_secs, sleep_secs, 16'($urandom_range(1, 9)),
                      16'($urandom_range(1, 255)), 16'($urandom_range(1, 6)));
            run_ticks(60);
        end
    endtask

    initial begin : result_sink
        @(posedge i_clk);
        forever begin
            if (long_hold) begin
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold = 1'b0;
            end else if (rx_idle && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat (idle_length()) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end
        end
    end

    task automatic check_field(input string name, input logic [7:0] want, got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (tick_results_due.size() == 0) begin
                $error("Result item arrived with no tick outstanding.");
                failures++;
            end else begin
                want = tick_results_due.pop_front();
                check_field("up_event", want.up_event, o_out_data.up_event);
                check_field("select_event", want.select_event, o_out_data.select_event);
                check_field("down_event", want.down_event, o_out_data.down_event);
                check_field("redraw_due", want.redraw_due, o_out_data.redraw_due);
                check_field("adc_due", want.adc_due, o_out_data.adc_due);
                check_field("second_pulse", want.second_pulse, o_out_data.second_pulse);
                check_field("log_due", want.log_due, o_out_data.log_due);
                check_field("seconds_now", want.seconds_now, o_out_data.seconds_now);
                check_field("backlight_level", want.backlight_level,
                            o_out_data.backlight_level);
                check_field("sleep_ok", want.sleep_ok, o_out_data.sleep_ok);
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_presses();
        test_reset_defaults();
        test_register_extremes();
        test_zero_periods();
        test_lowered_periods();
        test_long_second();
        test_backpressure();
        test_random_settings();
        i_in_valid <= 1'b0;
        for (int c = 0; c < DRAIN_LIMIT && tick_results_due.size() != 0; c++) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
        if (tick_results_due.size() != 0) begin
            $error("%0d expected results never arrived.", tick_results_due.size());
            failures++;
        end
        if (failures == 0) begin
            $display("PASS button_debounce_timebase");
        end else begin
            $display("FAIL button_debounce_timebase");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("FAIL button_debounce_timebase");
        $finish;
    end

endmodule

// ===== button_debounce_timebase.f =====
rtl/bdt_pkg.sv
rtl/button_debounce_timebase.sv
sim/button_debounce_timebase_tb.sv
